### rtl/delimiter_token_splitter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter token splitter
// Implication and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_TOKEN_SPLITTER_UNIT_ASSERT_SVH
`define DELIMITER_TOKEN_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define DTSU_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dtsu assertion failed");

// next-cycle implication, off while in reset
`define DTSU_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dtsu assertion failed");

`endif

### rtl/dtsu_pkg.sv
// ----------------------------------------------------------------------------
// dtsu_pkg
// Item types, register codes and helpers shared by the token splitter.
// ----------------------------------------------------------------------------
package dtsu_pkg;

  localparam int BYTE_W     = 8;
  localparam int DELIM_W    = 64;
  localparam int DELIM_NB   = DELIM_W / BYTE_W;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd1;

  localparam logic [DELIM_W-1:0] DELIM_RESET = 64'd32;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 4'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              string_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] token_byte;
    logic              token_end;
    logic              string_end;
    logic              run_last;
  } out_item_t;

  // delimiter byte k, zero outside the register
  function automatic logic [BYTE_W-1:0] delim_at(logic [DELIM_W-1:0] d, int k);
    logic [BYTE_W-1:0] r;
    r = '0;
    if (k >= 0 && k < DELIM_NB) begin
      r = d[BYTE_W*k +: BYTE_W];
    end
    return r;
  endfunction

endpackage

### rtl/dtsu_stream_if.sv
// ----------------------------------------------------------------------------
// dtsu_stream_if
// Valid/ready channel carrying one item per accepted handshake.
// ----------------------------------------------------------------------------
interface dtsu_stream_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### rtl/dtsu_cell.sv
// ----------------------------------------------------------------------------
// dtsu_cell
// One window cell: holds a recent byte, passes it on at each shift and
// compares it with the delimiter byte aligned to its position.
// ----------------------------------------------------------------------------
module dtsu_cell #(
  parameter int IDX = 0,
  parameter int LW  = 4
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [dtsu_pkg::BYTE_W-1:0]  byte_i,
  input  logic [dtsu_pkg::DELIM_W-1:0] delim_i,
  input  logic [LW-1:0]                len_i,
  output logic [dtsu_pkg::BYTE_W-1:0]  byte_o,
  output logic                         hit_o
);
  import dtsu_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic              in_use;
  logic [BYTE_W-1:0] expect_byte;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // cell IDX lines up with delimiter byte len-2-IDX
  assign in_use      = (IDX + 1) < int'(len_i);
  assign expect_byte = delim_at(delim_i, int'(len_i) - 2 - IDX);
  assign hit_o       = !in_use || (byte_q == expect_byte);
  assign byte_o      = byte_q;

endmodule

### rtl/delimiter_token_splitter_unit.sv
// ----------------------------------------------------------------------------
// delimiter_token_splitter_unit
// Splits a byte stream into tokens at a configurable multi-byte delimiter.
//
//   port     dir  item fields                                   role
//   text_i   in   text_byte, string_last                        string bytes
//   token_o  out  token_byte, token_end, string_end, run_last   token bytes
//   cfg_*    in   cfg_idx_i, cfg_wdata_i                        register writes
//
// One byte is taken per cycle while the output is free and no flush runs;
// the window compare is done in the cell row. A string's last byte, unless it
// completes a delimiter, flushes the held and pending bytes, input held off.
// A stalled output holds the chain; the output register frees on the take.
// Reset is asynchronous; delimiter resets to a single space.
// ----------------------------------------------------------------------------
`include "delimiter_token_splitter_unit_assert.svh"

module delimiter_token_splitter_unit #(
  parameter int MAX_DELIM = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtsu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtsu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dtsu_stream_if.sink                     text_i,
  dtsu_stream_if.source                   token_o
);
  import dtsu_pkg::*;

  localparam int LW = $clog2(MAX_DELIM + 1);
  localparam int IW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

  logic [DELIM_W-1:0] delim_q;
  logic [LEN_W-1:0]   dlen_q;

  logic [LW-1:0]     bsm_q, bsm_d;
  logic [BYTE_W-1:0] held_byte_q, held_byte_d;
  logic              held_valid_q, held_valid_d;
  logic              held_closed_q, held_closed_d;
  logic              flush_q, flush_d;
  logic [LW-1:0]     npend_q, npend_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  in_item_t          in_item;
  logic              cfg_clear;
  logic              adv, in_fire, flush_step;
  logic [LEN_W:0]    dlen_ext;
  logic [LW-1:0]     len, len_m1, rel_idx_w, pend_idx_w, cnt;
  logic              cnt_ok, match, emit;
  logic [BYTE_W-1:0] rel_byte;

  logic [BYTE_W-1:0]    win [MAX_DELIM];
  logic [MAX_DELIM-1:0] hits;

  assign in_item   = text_i.data;
  assign cfg_clear = cfg_we_i && (cfg_idx_i == REG_DELIM_BYTES || cfg_idx_i == REG_DELIM_LEN);

  assign adv          = !out_valid_q || token_o.ready;
  assign text_i.ready = !flush_q && adv;
  assign in_fire      = text_i.valid && text_i.ready;
  assign flush_step   = flush_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      dlen_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DELIM_BYTES) begin
        delim_q <= cfg_wdata_i[DELIM_W-1:0];
      end
      if (cfg_idx_i == REG_DELIM_LEN) begin
        dlen_q <= cfg_wdata_i[LEN_W-1:0];
      end
    end
  end

  // effective length: zero acts as one, clamp to MAX_DELIM
  assign dlen_ext = {1'b0, dlen_q};
  always_comb begin
    if (dlen_q == '0) begin
      len = LW'(1);
    end else if (dlen_ext > (LEN_W+1)'(MAX_DELIM)) begin
      len = LW'(MAX_DELIM);
    end else begin
      len = dlen_ext[LW-1:0];
    end
  end

  assign len_m1     = len - LW'(1);
  assign cnt        = (bsm_q >= LW'(MAX_DELIM)) ? LW'(MAX_DELIM) : bsm_q + LW'(1);
  assign cnt_ok     = cnt >= len;
  assign rel_idx_w  = len - LW'(2);
  assign pend_idx_w = npend_q - LW'(1);
  assign rel_byte   = (len == LW'(1)) ? in_item.text_byte : win[rel_idx_w[IW-1:0]];

  // window cells, index 0 newest
  for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cell
    logic [BYTE_W-1:0] chain_in;
    if (k == 0) begin : g_head
      assign chain_in = in_item.text_byte;
    end else begin : g_link
      assign chain_in = win[k-1];
    end
    dtsu_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (in_fire && !match),
      .byte_i  (chain_in),
      .delim_i (delim_q),
      .len_i   (len),
      .byte_o  (win[k]),
      .hit_o   (hits[k])
    );
  end

  assign match = cnt_ok && (delim_at(delim_q, int'(len) - 1) == in_item.text_byte) && (&hits);

  always_comb begin
    bsm_d         = bsm_q;
    held_byte_d   = held_byte_q;
    held_valid_d  = held_valid_q;
    held_closed_d = held_closed_q;
    flush_d       = flush_q;
    npend_d       = npend_q;
    emit          = 1'b0;
    out_d         = out_q;
    if (in_fire) begin
      if (match) begin
        if (in_item.string_last) begin
          emit             = held_valid_q;
          out_d.token_byte = held_byte_q;
          out_d.token_end  = 1'b1;
          out_d.string_end = 1'b1;
          out_d.run_last   = 1'b1;
          bsm_d            = '0;
          held_valid_d     = 1'b0;
          held_closed_d    = 1'b0;
        end else begin
          held_closed_d = held_closed_q | held_valid_q;
          bsm_d         = '0;
        end
      end else begin
        emit             = cnt_ok && held_valid_q;
        out_d.token_byte = held_byte_q;
        out_d.token_end  = held_closed_q;
        out_d.string_end = 1'b0;
        out_d.run_last   = !in_item.string_last;
        if (cnt_ok) begin
          held_byte_d   = rel_byte;
          held_valid_d  = 1'b1;
          held_closed_d = 1'b0;
        end
        bsm_d = cnt;
        if (in_item.string_last) begin
          flush_d = 1'b1;
          npend_d = cnt_ok ? len_m1 : cnt;
        end
      end
    end else if (flush_step) begin
      emit = 1'b1;
      if (held_valid_q) begin
        out_d.token_byte = held_byte_q;
        out_d.token_end  = (npend_q == '0) || held_closed_q;
        out_d.string_end = (npend_q == '0);
        out_d.run_last   = (npend_q == '0);
        held_valid_d     = 1'b0;
        held_closed_d    = 1'b0;
        if (npend_q == '0) begin
          flush_d = 1'b0;
          bsm_d   = '0;
        end
      end else begin
        out_d.token_byte = win[pend_idx_w[IW-1:0]];
        out_d.token_end  = (npend_q == LW'(1));
        out_d.string_end = (npend_q == LW'(1));
        out_d.run_last   = (npend_q == LW'(1));
        npend_d          = pend_idx_w;
        if (npend_q == LW'(1)) begin
          flush_d = 1'b0;
          bsm_d   = '0;
        end
      end
    end
    if (cfg_clear) begin
      bsm_d         = '0;
      held_valid_d  = 1'b0;
      held_closed_d = 1'b0;
      flush_d       = 1'b0;
      npend_d       = '0;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !token_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsm_q         <= '0;
      held_valid_q  <= 1'b0;
      held_closed_q <= 1'b0;
      flush_q       <= 1'b0;
      npend_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      bsm_q         <= bsm_d;
      held_valid_q  <= held_valid_d;
      held_closed_q <= held_closed_d;
      flush_q       <= flush_d;
      npend_q       <= npend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_byte_q <= held_byte_d;
    out_q       <= out_d;
  end

  assign token_o.valid = out_valid_q;
  assign token_o.data  = out_q;

  `DTSU_ASSERT_NXT(a_last_starts_flush, clk_i, rst_ni, in_fire && in_item.string_last && !match && !cfg_clear, flush_q)
  `DTSU_ASSERT_IMP(a_closed_needs_held, clk_i, rst_ni, held_closed_q, held_valid_q)
  `DTSU_ASSERT_IMP(a_pend_in_range, clk_i, rst_ni, flush_q, npend_q < LW'(MAX_DELIM))
  `DTSU_ASSERT_IMP(a_string_end_marks, clk_i, rst_ni, out_valid_q && out_q.string_end, out_q.token_end && out_q.run_last)
  `DTSU_ASSERT_IMP(a_count_sat, clk_i, rst_ni, 1'b1, bsm_q <= LW'(MAX_DELIM))

endmodule
